// File: rtl/hkrb_pkg.sv
package hkrb_pkg;

  localparam int SLOT_COUNT_DEFAULT = 6;
  localparam int SHOWN_SLOTS = 6;
  localparam int USAGE_W = 8;

  localparam logic [2:0] MODE_KEY_PRESS     = 3'd0;
  localparam logic [2:0] MODE_KEY_RELEASE   = 3'd1;
  localparam logic [2:0] MODE_MEDIA_PRESS   = 3'd2;
  localparam logic [2:0] MODE_MEDIA_RELEASE = 3'd3;
  localparam logic [2:0] MODE_RELEASE_ALL   = 3'd4;

  localparam logic REPORT_KEYBOARD = 1'b0;
  localparam logic REPORT_MEDIA    = 1'b1;

  localparam logic [7:0] USAGE_BASE = 8'd136;
  localparam logic [7:0] MOD_BASE   = 8'd128;
  localparam logic [7:0] SHIFT_MASK = 8'h02;
  localparam logic [7:0] USAGE_MASK = 8'h7F;

  localparam logic [7:0] US_ASCII [128] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
    8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
    8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
    8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
    8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
    8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
    8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
    8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
    8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
    8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
    8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
    8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
  };

  typedef struct packed {
    logic                 valid;
    logic                 rel;
    logic                 held;
    logic                 placed;
    logic [USAGE_W-1:0]   usage;
  } pkt_t;

  typedef struct packed {
    logic                 mapped;
    logic [USAGE_W-1:0]   usage;
    logic [7:0]           mod_mask;
  } xlate_t;

  function automatic xlate_t translate(input logic [7:0] code);
    xlate_t     r;
    logic [7:0] e;
    r.mapped   = 1'b1;
    r.usage    = '0;
    r.mod_mask = '0;
    e = US_ASCII[code[6:0]];
    if (code >= USAGE_BASE) begin
      r.usage = code - USAGE_BASE;
    end else if (code >= MOD_BASE) begin
      r.mod_mask = 8'd1 << code[2:0];
    end else if (e == 8'h00) begin
      r.mapped = 1'b0;
    end else begin
      if (e[7]) begin
        r.mod_mask = SHIFT_MASK;
      end
      r.usage = e & USAGE_MASK;
    end
    return r;
  endfunction

endpackage

// File: rtl/hkrb_cell.sv
module hkrb_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear_all,
  input  hkrb_pkg::pkt_t                pkt_in,
  input  logic [hkrb_pkg::USAGE_W-1:0]  probe,
  output hkrb_pkg::pkt_t                pkt_out,
  output logic                          match,
  output logic [hkrb_pkg::USAGE_W-1:0]  slot
);

  logic hit;
  logic take;

  assign match = (slot == probe);
  assign hit   = (slot == pkt_in.usage);
  assign take  = pkt_in.valid && !pkt_in.rel && !pkt_in.held && !pkt_in.placed
                 && (slot == '0);

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      slot <= '0;
    end else if (pkt_in.valid) begin
      if (take) begin
        slot <= pkt_in.usage;
      end else if (pkt_in.rel && hit) begin
        slot <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_out.valid <= 1'b0;
    end else begin
      pkt_out.valid <= pkt_in.valid;
    end
    pkt_out.rel    <= pkt_in.rel;
    pkt_out.held   <= pkt_in.held;
    pkt_out.placed <= pkt_in.placed || take;
    pkt_out.usage  <= pkt_in.usage;
  end

endmodule

// File: rtl/hid_keyboard_report_builder_core.sv
// Builds boot keyboard reports (modifier byte and up to six key slots) and a
// 16-bit media report from key, media and release-all events. The key slots
// live in a chain of SLOT_COUNT cells, and a press or release of a nonzero
// usage travels down that chain one cell per cycle. Such an item passes the
// launch state, the cells and the emit state, and its report is then loaded
// into the output register; the next item is taken once the block is idle
// again. Modifier-only keys and media events go straight to the emit state.
// Release all emits a keyboard report and then a media report. Input items
// are taken only while no event is in flight, but a finished report may wait
// in the output register while the next item is accepted. Reports are only
// produced while host_connected is set; the state is updated either way.
module hid_keyboard_report_builder_core #(
  parameter int SLOT_COUNT = hkrb_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // key_code[7:0], media_bits[23:8], host_connected[24]
  input  logic [2:0]  s_axis_tuser,  // mode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // modifier_bits[7:0], slot_zero..slot_five[55:8],
                                     // media_state[71:56]
  output logic        m_axis_tuser,  // report_kind
  output logic        m_axis_tlast   // last
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LAUNCH = 2'd1;
  localparam logic [1:0] S_WALK   = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  localparam int UW = hkrb_pkg::USAGE_W;

  logic [1:0]            state;
  logic [7:0]            mods;
  logic [15:0]           media;
  logic [UW-1:0]         pend_usage;
  logic                  pend_rel;
  logic                  pend_up;
  logic                  emit_kind;
  logic                  emit_last;
  logic                  clear_all;

  logic [7:0]            in_code;
  logic [15:0]           in_media;
  logic                  in_up;
  logic [2:0]            in_mode;
  logic                  accept;
  hkrb_pkg::xlate_t      tr;

  hkrb_pkg::pkt_t        chain [SLOT_COUNT+1];
  logic [SLOT_COUNT-1:0] match;
  logic [UW-1:0]         slot_vals [SLOT_COUNT];
  logic [UW-1:0]         shown [hkrb_pkg::SHOWN_SLOTS];
  logic                  out_load;

  assign in_code  = s_axis_tdata[7:0];
  assign in_media = s_axis_tdata[23:8];
  assign in_up    = s_axis_tdata[24];
  assign in_mode  = s_axis_tuser;
  assign tr       = hkrb_pkg::translate(in_code);

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign clear_all     = accept && (in_mode == hkrb_pkg::MODE_RELEASE_ALL);
  assign out_load      = (state == S_EMIT) && (!m_axis_tvalid || m_axis_tready);

  assign chain[0].valid  = (state == S_LAUNCH);
  assign chain[0].rel    = pend_rel;
  assign chain[0].held   = |match;
  assign chain[0].placed = 1'b0;
  assign chain[0].usage  = pend_usage;

  for (genvar gi = 0; gi < SLOT_COUNT; gi++) begin : g_cell
    hkrb_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear_all (clear_all),
      .pkt_in    (chain[gi]),
      .probe     (pend_usage),
      .pkt_out   (chain[gi+1]),
      .match     (match[gi]),
      .slot      (slot_vals[gi])
    );
  end

  for (genvar gs = 0; gs < hkrb_pkg::SHOWN_SLOTS; gs++) begin : g_shown
    if (gs < SLOT_COUNT) begin : g_real
      assign shown[gs] = slot_vals[gs];
    end else begin : g_zero
      assign shown[gs] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mods      <= '0;
      media     <= '0;
      emit_kind <= hkrb_pkg::REPORT_KEYBOARD;
      emit_last <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pend_up <= in_up;
            case (in_mode) inside
              hkrb_pkg::MODE_KEY_PRESS, hkrb_pkg::MODE_KEY_RELEASE: begin
                if (tr.mapped) begin
                  pend_usage <= tr.usage;
                  pend_rel   <= (in_mode == hkrb_pkg::MODE_KEY_RELEASE);
                  if (in_mode == hkrb_pkg::MODE_KEY_RELEASE) begin
                    mods <= mods & ~tr.mod_mask;
                  end else begin
                    mods <= mods | tr.mod_mask;
                  end
                  if (tr.usage != '0) begin
                    state <= S_LAUNCH;
                  end else if (in_up) begin
                    emit_kind <= hkrb_pkg::REPORT_KEYBOARD;
                    emit_last <= 1'b1;
                    state     <= S_EMIT;
                  end
                end
              end
              hkrb_pkg::MODE_MEDIA_PRESS, hkrb_pkg::MODE_MEDIA_RELEASE: begin
                if (in_mode == hkrb_pkg::MODE_MEDIA_PRESS) begin
                  media <= media | in_media;
                end else begin
                  media <= media & ~in_media;
                end
                if (in_up) begin
                  emit_kind <= hkrb_pkg::REPORT_MEDIA;
                  emit_last <= 1'b1;
                  state     <= S_EMIT;
                end
              end
              hkrb_pkg::MODE_RELEASE_ALL: begin
                mods  <= '0;
                media <= '0;
                if (in_up) begin
                  emit_kind <= hkrb_pkg::REPORT_KEYBOARD;
                  emit_last <= 1'b0;
                  state     <= S_EMIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_LAUNCH: begin
          state <= S_WALK;
        end
        S_WALK: begin
          if (chain[SLOT_COUNT].valid) begin
            if (pend_up && (chain[SLOT_COUNT].rel || chain[SLOT_COUNT].held
                            || chain[SLOT_COUNT].placed)) begin
              emit_kind <= hkrb_pkg::REPORT_KEYBOARD;
              emit_last <= 1'b1;
              state     <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (out_load) begin
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              emit_kind <= hkrb_pkg::REPORT_MEDIA;
              emit_last <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {media, shown[5], shown[4], shown[3], shown[2], shown[1], shown[0],
                       mods};
      m_axis_tuser <= emit_kind;
      m_axis_tlast <= emit_last;
    end
  end

endmodule

// File: rtl/hkrb_checker.sv
module hkrb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled report keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output report changed while stalled");

  // No report is pending right after reset.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("report present after reset");

  // Only release all produces a non-final report, and it is an all-zero keyboard report.
  a_first_of_pair: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |->
      (m_axis_tuser == 1'b0) && (m_axis_tdata == 72'd0))
    else $error("non-final report is not an empty keyboard report");

  // The first report of a release all is followed by its media report.
  a_pair_follow: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tuser && m_axis_tlast && (m_axis_tdata == 72'd0))
    else $error("media report of release all missing");

endmodule

bind hid_keyboard_report_builder_core hkrb_checker u_hkrb_checker (.*);
